// File: rtl/lps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lps_pkg - shared definitions for the linear prime sieve
// Sizes, status codes and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package lps_pkg;

  // sieve span and prime store depth
  localparam int unsigned MAX_VALUE   = 2097152;
  localparam int unsigned PRIME_SLOTS = 262144;

  // fixed field widths
  localparam int unsigned VAL_W   = 21;
  localparam int unsigned COUNT_W = 18;
  localparam int unsigned STAT_W  = 2;

  // derived sizes
  localparam int unsigned MARK_AW  = $clog2(MAX_VALUE);
  localparam int unsigned MARK_TOP = MAX_VALUE - 1;
  localparam int unsigned SLOT_AW  = $clog2(PRIME_SLOTS);
  localparam int unsigned SLOT_CW  = $clog2(PRIME_SLOTS + 1);
  localparam int unsigned PROD_W   = 2 * VAL_W;
  localparam int unsigned REM_CW   = $clog2(VAL_W);

  localparam logic [VAL_W-1:0] LIMIT_RST = VAL_W'(2097151);
  localparam logic [VAL_W-1:0] FIRST_VAL = VAL_W'(2);

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_ORDER = 2'd1,
    ST_RANGE = 2'd2
  } lps_status_t;

  // controller -> datapath
  typedef struct packed {
    logic clr_step;   // clear one mark, advance sweep address
    logic latch_in;   // capture the input item
    logic check;      // record order/range verdict
    logic rec_prime;  // act on the mark of the value
    logic mul;        // register value * prime
    logic mark_set;   // mark the product composite, start remainder
    logic j_inc;      // next prime in the walk
    logic load_out;   // fill the output register
  } lps_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;
    logic bad;
    logic walk_end;
    logic p_zero;
    logic over;
    logic rem_done;
    logic rem_zero;
  } lps_sts_t;

endpackage

// File: rtl/lps_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lps_ram - generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module lps_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/lps_rem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lps_rem - serial remainder unit
// Restoring division, one dividend bit per cycle; flags a zero remainder.
// ----------------------------------------------------------------------------
module lps_rem (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [lps_pkg::VAL_W-1:0] dividend,
  input  logic [lps_pkg::VAL_W-1:0] divisor,
  output logic                      done,
  output logic                      rem_zero
);

  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [lps_pkg::REM_CW-1:0] cnt_r, cnt_nxt;
  logic [lps_pkg::VAL_W-1:0]  rem_r, rem_nxt;
  logic [lps_pkg::VAL_W-1:0]  dvd_r, dvd_nxt;
  logic [lps_pkg::VAL_W-1:0]  dsr_r, dsr_nxt;
  logic [lps_pkg::VAL_W:0]    trial;

  assign trial = {rem_r, dvd_r[lps_pkg::VAL_W-1]};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      dvd_nxt  = dividend;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[lps_pkg::VAL_W-2:0], 1'b0};
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = lps_pkg::VAL_W'(trial - {1'b0, dsr_r});
      end else begin
        rem_nxt = lps_pkg::VAL_W'(trial);
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == lps_pkg::REM_CW'(lps_pkg::VAL_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done     = done_r;
  assign rem_zero = (rem_r == '0);

endmodule

// File: rtl/lps_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lps_dp - sieve datapath
// Mark and prime stores, counters, product register, remainder unit and
// the output payload register.
// ----------------------------------------------------------------------------
module lps_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lps_pkg::lps_cmd_t           cmd,
  output lps_pkg::lps_sts_t           sts,
  input  logic                        cfg_we,
  input  logic [lps_pkg::VAL_W-1:0]   cfg_limit,
  input  logic [lps_pkg::VAL_W-1:0]   in_value,
  output logic                        out_is_prime,
  output logic [lps_pkg::COUNT_W-1:0] out_prime_count,
  output logic [lps_pkg::STAT_W-1:0]  out_status
);

  logic [lps_pkg::VAL_W-1:0]   limit_r, limit_nxt;
  logic [lps_pkg::VAL_W-1:0]   lim_eff;
  logic [lps_pkg::VAL_W-1:0]   v_r, v_nxt;
  logic [lps_pkg::VAL_W-1:0]   next_exp_r, next_exp_nxt;
  logic [lps_pkg::COUNT_W-1:0] found_r, found_nxt;
  logic [lps_pkg::SLOT_CW-1:0] stored_r, stored_nxt;
  logic [lps_pkg::SLOT_CW-1:0] j_r, j_nxt;
  logic [lps_pkg::MARK_AW-1:0] clr_addr_r, clr_addr_nxt;
  logic [lps_pkg::PROD_W-1:0]  prod_r, prod_nxt;
  logic [lps_pkg::VAL_W-1:0]   p_r, p_nxt;
  logic                        res_prime_r, res_prime_nxt;
  lps_pkg::lps_status_t        res_stat_r, res_stat_nxt;
  lps_pkg::lps_status_t        verdict;
  logic                        out_prime_r, out_prime_nxt;
  logic [lps_pkg::COUNT_W-1:0] out_count_r, out_count_nxt;
  lps_pkg::lps_status_t        out_stat_r, out_stat_nxt;

  logic                        mark_we;
  logic [lps_pkg::MARK_AW-1:0] mark_waddr;
  logic                        mark_wdata;
  logic                        mark_rdata;
  logic                        prime_we;
  logic [lps_pkg::VAL_W-1:0]   prime_rdata;
  logic                        slots_full;
  logic                        rem_done;
  logic                        rem_zero;

  // effective limit: never past the top of the mark store
  assign lim_eff = (32'(limit_r) > 32'(lps_pkg::MARK_TOP)) ?
                   lps_pkg::VAL_W'(lps_pkg::MARK_TOP) : limit_r;

  always_comb begin
    if ((v_r < lps_pkg::FIRST_VAL) || (v_r != next_exp_r)) begin
      verdict = lps_pkg::ST_ORDER;
    end else if (v_r > lim_eff) begin
      verdict = lps_pkg::ST_RANGE;
    end else begin
      verdict = lps_pkg::ST_OK;
    end
  end

  assign slots_full = (stored_r == lps_pkg::SLOT_CW'(lps_pkg::PRIME_SLOTS));
  assign prime_we   = cmd.rec_prime && !mark_rdata && !slots_full;

  // mark store writes: clearing sweep or composite marking
  assign mark_we    = cmd.clr_step || cmd.mark_set;
  assign mark_waddr = cmd.clr_step ? clr_addr_r : lps_pkg::MARK_AW'(prod_r);
  assign mark_wdata = !cmd.clr_step;

  always_comb begin
    limit_nxt     = limit_r;
    v_nxt         = v_r;
    next_exp_nxt  = next_exp_r;
    found_nxt     = found_r;
    stored_nxt    = stored_r;
    j_nxt         = j_r;
    clr_addr_nxt  = clr_addr_r;
    prod_nxt      = prod_r;
    p_nxt         = p_r;
    res_prime_nxt = res_prime_r;
    res_stat_nxt  = res_stat_r;
    out_prime_nxt = out_prime_r;
    out_count_nxt = out_count_r;
    out_stat_nxt  = out_stat_r;

    if (cfg_we) begin
      limit_nxt = cfg_limit;
    end
    if (cmd.clr_step) begin
      clr_addr_nxt = clr_addr_r + 1'b1;
    end
    if (cmd.latch_in) begin
      v_nxt = in_value;
    end
    if (cmd.check) begin
      res_stat_nxt  = verdict;
      res_prime_nxt = 1'b0;
    end
    if (cmd.rec_prime) begin
      res_prime_nxt = !mark_rdata;
      next_exp_nxt  = v_r + 1'b1;
      j_nxt         = '0;
      if (!mark_rdata) begin
        if (!slots_full) begin
          stored_nxt = stored_r + 1'b1;
        end
        if (found_r != '1) begin
          found_nxt = found_r + 1'b1;
        end
      end
    end
    if (cmd.mul) begin
      prod_nxt = lps_pkg::PROD_W'(v_r) * lps_pkg::PROD_W'(prime_rdata);
      p_nxt    = prime_rdata;
    end
    if (cmd.j_inc) begin
      j_nxt = j_r + 1'b1;
    end
    if (cmd.load_out) begin
      out_prime_nxt = res_prime_r;
      out_count_nxt = found_r;
      out_stat_nxt  = res_stat_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r    <= lps_pkg::LIMIT_RST;
      next_exp_r <= lps_pkg::FIRST_VAL;
      found_r    <= '0;
      stored_r   <= '0;
      j_r        <= '0;
      clr_addr_r <= '0;
    end else begin
      limit_r    <= limit_nxt;
      next_exp_r <= next_exp_nxt;
      found_r    <= found_nxt;
      stored_r   <= stored_nxt;
      j_r        <= j_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
    v_r         <= v_nxt;
    prod_r      <= prod_nxt;
    p_r         <= p_nxt;
    res_prime_r <= res_prime_nxt;
    res_stat_r  <= res_stat_nxt;
    out_prime_r <= out_prime_nxt;
    out_count_r <= out_count_nxt;
    out_stat_r  <= out_stat_nxt;
  end

  lps_ram #(
    .WIDTH (1),
    .DEPTH (lps_pkg::MAX_VALUE)
  ) u_marks (
    .clk   (clk),
    .we    (mark_we),
    .waddr (mark_waddr),
    .wdata (mark_wdata),
    .raddr (lps_pkg::MARK_AW'(v_r)),
    .rdata (mark_rdata)
  );

  lps_ram #(
    .WIDTH (lps_pkg::VAL_W),
    .DEPTH (lps_pkg::PRIME_SLOTS)
  ) u_primes (
    .clk   (clk),
    .we    (prime_we),
    .waddr (stored_r[lps_pkg::SLOT_AW-1:0]),
    .wdata (v_r),
    .raddr (j_r[lps_pkg::SLOT_AW-1:0]),
    .rdata (prime_rdata)
  );

  lps_rem u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.mark_set),
    .dividend (v_r),
    .divisor  (p_r),
    .done     (rem_done),
    .rem_zero (rem_zero)
  );

  always_comb begin
    sts.clr_last = (clr_addr_r == lps_pkg::MARK_AW'(lps_pkg::MARK_TOP));
    sts.bad      = (verdict != lps_pkg::ST_OK);
    sts.walk_end = (j_r >= stored_r);
    sts.p_zero   = (prime_rdata == '0);
    sts.over     = (prod_r > lps_pkg::PROD_W'(lim_eff));
    sts.rem_done = rem_done;
    sts.rem_zero = rem_zero;
  end

  assign out_is_prime    = out_prime_r;
  assign out_prime_count = out_count_r;
  assign out_status      = out_stat_r;

endmodule

// File: rtl/lps_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lps_ctrl - sieve controller
// Sequences the mark clear after reset and the classification and prime
// walk of each item, and owns both handshakes.
// ----------------------------------------------------------------------------
module lps_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  lps_pkg::lps_sts_t sts,
  output lps_pkg::lps_cmd_t cmd
);

  typedef enum logic [8:0] {
    S_CLEAR    = 9'b000000001,
    S_IDLE     = 9'b000000010,
    S_CHECK    = 9'b000000100,
    S_MREAD    = 9'b000001000,
    S_WALK_RD  = 9'b000010000,
    S_WALK_MUL = 9'b000100000,
    S_WALK_CMP = 9'b001000000,
    S_WALK_DIV = 9'b010000000,
    S_FINISH   = 9'b100000000
  } lps_state_t;

  lps_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        state_nxt = sts.bad ? S_FINISH : S_MREAD;
      end
      S_MREAD: begin
        cmd.rec_prime = 1'b1;
        state_nxt     = S_WALK_RD;
      end
      S_WALK_RD: begin
        state_nxt = sts.walk_end ? S_FINISH : S_WALK_MUL;
      end
      S_WALK_MUL: begin
        if (sts.p_zero) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.mul   = 1'b1;
          state_nxt = S_WALK_CMP;
        end
      end
      S_WALK_CMP: begin
        if (sts.over) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.mark_set = 1'b1;
          state_nxt    = S_WALK_DIV;
        end
      end
      S_WALK_DIV: begin
        if (sts.rem_done) begin
          if (sts.rem_zero) begin
            state_nxt = S_FINISH;
          end else begin
            cmd.j_inc = 1'b1;
            state_nxt = S_WALK_RD;
          end
        end
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// File: rtl/linear_prime_sieve.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_prime_sieve - Euler's linear sieve, one integer per item
// Classifies the integers 2, 3, 4, ... in turn as prime or composite and
// keeps a running prime count.
// ----------------------------------------------------------------------------
// Usage: after reset the block clears its composite-mark store, one mark a
// cycle, and takes no item until its MAX_VALUE (2097152) marks are clear; the
// limit register can be written at any time during that pass. Each item
// then carries the next integer of the sequence, starting at 2, and gives
// one result: the prime flag, the running prime count and a status (ok,
// out of order, above limit). A flagged item changes no state. For an ok
// item each walk step reads the prime store, forms value * prime, checks
// it against the limit and marks it, then waits for the bit-serial remainder
// unit (21 shift steps and the done flag). The walk ends at the least prime
// factor of the value, inside that step, or when the stored primes run out
// or when the product passes the limit. Most items walk one or two primes
// and a large prime walks many. A finished result sits in the output
// register while the next item is accepted and worked on.
// Configuration: cfg_limit is taken whenever cfg_valid is high (cfg_ready
// is tied high); write it only while no item is in flight.
// ----------------------------------------------------------------------------
module linear_prime_sieve (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [lps_pkg::VAL_W-1:0]   cfg_limit,
  // input items
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [lps_pkg::VAL_W-1:0]   in_value,
  // result items
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_is_prime,
  output logic [lps_pkg::COUNT_W-1:0] out_prime_count,
  output logic [lps_pkg::STAT_W-1:0]  out_status
);

  lps_pkg::lps_cmd_t cmd;
  lps_pkg::lps_sts_t sts;

  // the limit register always takes a write
  assign cfg_ready = 1'b1;

  lps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  lps_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_limit       (cfg_limit),
    .in_value        (in_value),
    .out_is_prime    (out_is_prime),
    .out_prime_count (out_prime_count),
    .out_status      (out_status)
  );

endmodule
